>>> rtl/heat_diffusion_stencil_defines.svh
// ----------------------------------------------------------------------------
// heat diffusion stencil assertion macros
// shared property forms used by the rtl modules of the stencil block
// ----------------------------------------------------------------------------
`ifndef HEAT_DIFFUSION_STENCIL_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HDS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg
// types, widths and constants shared by the heat diffusion stencil block
// ----------------------------------------------------------------------------
`default_nettype none

package hds_pkg;

    // grid and value geometry
    localparam int VALUE_BITS     = 16;
    localparam int MAX_WIDTH      = 1024;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = 16;
    localparam int WIDTH_REG_BITS = COL_BITS + 1;
    localparam int GAIN_BITS      = 16;
    localparam int MIN_DIM        = 3;

    // datapath widths
    localparam int LAP_BITS   = VALUE_BITS + 3;
    localparam int PROD_BITS  = LAP_BITS + GAIN_BITS + 1;
    localparam int FRAC_BITS  = GAIN_BITS;
    localparam int Q_BITS     = PROD_BITS - FRAC_BITS + 1;
    localparam int SUM_BITS   = Q_BITS + 1;
    localparam int ROUND_BIAS = 2 ** (FRAC_BITS - 1);

    // output queue
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // configuration port
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_GRID_WIDTH     = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_GRID_HEIGHT    = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_DIFFUSION_GAIN = 2'd2;

    localparam logic [WIDTH_REG_BITS-1:0] GRID_WIDTH_RST  = 11'd22;
    localparam logic [ROW_BITS-1:0]       GRID_HEIGHT_RST = 16'd22;
    localparam logic [GAIN_BITS-1:0]      GAIN_RST        = 16'd16384;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    localparam t_value VAL_MAX = t_value'(2 ** (VALUE_BITS - 1) - 1);
    localparam t_value VAL_MIN = t_value'(-(2 ** (VALUE_BITS - 1)));

    // per-cell bookkeeping carried down the pipeline
    typedef struct packed {
        logic                produce;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } t_meta;

    // stage one contents
    typedef struct packed {
        t_value x;
        t_meta  meta;
    } t_stage;

    // one finished result
    typedef struct packed {
        t_value              new_value;
        logic [ROW_BITS-1:0] out_row;
        logic [COL_BITS-1:0] out_col;
        logic                last_of_frame;
    } t_result;

    // occupancy of the arithmetic stages
    typedef struct packed {
        logic s2_valid;
        logic s3_valid;
    } t_pipe_status;

endpackage

`default_nettype wire

>>> rtl/hds_stream_if.sv
// ----------------------------------------------------------------------------
// hds stream interfaces
// valid/ready channels for grid cells in and updated cells out
// ----------------------------------------------------------------------------
`default_nettype none

// padded grid cells, raster order
interface hds_in_if;
    logic           valid;
    logic           ready;
    hds_pkg::t_value cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

// updated interior cells
interface hds_out_if;
    logic                          valid;
    logic                          ready;
    hds_pkg::t_value               new_value;
    logic [hds_pkg::ROW_BITS-1:0]  out_row;
    logic [hds_pkg::COL_BITS-1:0]  out_col;
    logic                          last_of_frame;

    modport source (output valid, output new_value, output out_row, output out_col,
                    output last_of_frame, input ready);
    modport sink   (input valid, input new_value, input out_row, input out_col,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/hds_line_buf.sv
// ----------------------------------------------------------------------------
// hds_line_buf
// two row buffers: the row above and the row two above the incoming cell
// ----------------------------------------------------------------------------
`default_nettype none

module hds_line_buf (
    input  wire                           i_clk,
    input  wire                           i_rd_en,
    input  wire  [hds_pkg::COL_BITS-1:0]  i_rd_addr,
    input  wire                           i_wr_en,
    input  wire  [hds_pkg::COL_BITS-1:0]  i_wr_addr,
    input  hds_pkg::t_value               i_wr_x,
    output hds_pkg::t_value               o_rd_above,
    output hds_pkg::t_value               o_rd_two_above
);

    hds_pkg::t_value r_above_mem     [hds_pkg::MAX_WIDTH];
    hds_pkg::t_value r_two_above_mem [hds_pkg::MAX_WIDTH];
    hds_pkg::t_value r_rd_above;
    hds_pkg::t_value r_rd_two_above;

    // registered read at the column of the accepted cell
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_above     <= r_above_mem[i_rd_addr];
            r_rd_two_above <= r_two_above_mem[i_rd_addr];
        end
    end

    // in the cycle after the read the column shifts down by one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_two_above_mem[i_wr_addr] <= r_rd_above;
            r_above_mem[i_wr_addr]     <= i_wr_x;
        end
    end

    assign o_rd_above     = r_rd_above;
    assign o_rd_two_above = r_rd_two_above;

endmodule

`default_nettype wire

>>> rtl/hds_update.sv
// ----------------------------------------------------------------------------
// hds_update
// 3x3 window, laplacian times gain, rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

`include "heat_diffusion_stencil_defines.svh"

module hds_update (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s1_valid,
    input  hds_pkg::t_stage                i_s1,
    input  hds_pkg::t_value                i_rd_above,
    input  hds_pkg::t_value                i_rd_two_above,
    input  wire  [hds_pkg::GAIN_BITS-1:0]  i_gain,
    output hds_pkg::t_pipe_status          o_status,
    output hds_pkg::t_result               o_res
);

    // window cells that feed the stencil
    hds_pkg::t_value r_win_top1, r_win_top2;
    hds_pkg::t_value r_win_mid0, r_win_mid1, r_win_mid2;
    hds_pkg::t_value r_win_bot1, r_win_bot2;

    logic           r_s2_valid;
    hds_pkg::t_meta r_s2_meta;

    logic                                 r_s3_valid;
    hds_pkg::t_meta                       r_s3_meta;
    logic signed [hds_pkg::PROD_BITS-1:0] r_s3_prod;
    hds_pkg::t_value                      r_s3_u;

    logic signed [hds_pkg::LAP_BITS-1:0]  w_lap;
    logic signed [hds_pkg::GAIN_BITS:0]   w_gain_s;
    logic signed [hds_pkg::PROD_BITS-1:0] w_prod;
    logic signed [hds_pkg::PROD_BITS:0]   w_biased;
    logic signed [hds_pkg::Q_BITS-1:0]    w_q;
    logic signed [hds_pkg::SUM_BITS-1:0]  w_sum;
    hds_pkg::t_value                      w_new;

    // window shift, one column per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_top1 <= '0;
            r_win_top2 <= '0;
            r_win_mid0 <= '0;
            r_win_mid1 <= '0;
            r_win_mid2 <= '0;
            r_win_bot1 <= '0;
            r_win_bot2 <= '0;
        end else if (i_s1_valid) begin
            r_win_top1 <= r_win_top2;
            r_win_top2 <= i_rd_two_above;
            r_win_mid0 <= r_win_mid1;
            r_win_mid1 <= r_win_mid2;
            r_win_mid2 <= i_rd_above;
            r_win_bot1 <= r_win_bot2;
            r_win_bot2 <= i_s1.x;
        end
    end

    // stage two: laplacian and product
    always_comb begin
        w_lap = hds_pkg::LAP_BITS'(r_win_top1) + hds_pkg::LAP_BITS'(r_win_bot1)
              + hds_pkg::LAP_BITS'(r_win_mid0) + hds_pkg::LAP_BITS'(r_win_mid2)
              - (hds_pkg::LAP_BITS'(r_win_mid1) <<< 2);
        w_gain_s = signed'({1'b0, i_gain});
        w_prod   = hds_pkg::PROD_BITS'(w_gain_s) * hds_pkg::PROD_BITS'(w_lap);
    end

    // stage three: round to nearest, add, saturate
    always_comb begin
        w_biased = (hds_pkg::PROD_BITS + 1)'(r_s3_prod)
                 + (hds_pkg::PROD_BITS + 1)'(hds_pkg::ROUND_BIAS);
        w_q      = w_biased[hds_pkg::PROD_BITS:hds_pkg::FRAC_BITS];
        w_sum    = hds_pkg::SUM_BITS'(r_s3_u) + hds_pkg::SUM_BITS'(w_q);
        if (w_sum > hds_pkg::SUM_BITS'(hds_pkg::VAL_MAX)) begin
            w_new = hds_pkg::VAL_MAX;
        end else if (w_sum < hds_pkg::SUM_BITS'(hds_pkg::VAL_MIN)) begin
            w_new = hds_pkg::VAL_MIN;
        end else begin
            w_new = hds_pkg::VALUE_BITS'(w_sum);
        end
    end

    // stage valids, only cells that yield a result go past stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1_valid && i_s1.meta.produce;
            r_s3_valid <= r_s2_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_s2_meta <= i_s1.meta;
        r_s3_meta <= r_s2_meta;
        r_s3_prod <= w_prod;
        r_s3_u    <= r_win_mid1;
    end

    assign o_status.s2_valid = r_s2_valid;
    assign o_status.s3_valid = r_s3_valid;

    assign o_res.new_value     = w_new;
    assign o_res.out_row       = r_s3_meta.row;
    assign o_res.out_col       = r_s3_meta.col;
    assign o_res.last_of_frame = r_s3_meta.last;

    `HDS_ASSERT_NEXT(a_s2_to_s3, i_clk, i_rst_n, r_s2_valid, r_s3_valid, "stage two result lost")
    `HDS_ASSERT_NEXT(a_s1_to_s2, i_clk, i_rst_n, i_s1_valid && i_s1.meta.produce, r_s2_valid, "interior cell did not enter stage two")

endmodule

`default_nettype wire

>>> rtl/hds_out_fifo.sv
// ----------------------------------------------------------------------------
// hds_out_fifo
// small result queue that decouples the pipeline from the output stall
// ----------------------------------------------------------------------------
`default_nettype none

`include "heat_diffusion_stencil_defines.svh"

module hds_out_fifo (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_push,
    input  hds_pkg::t_result                   i_data,
    output logic [hds_pkg::FIFO_CNT_BITS-1:0]  o_count,
    hds_out_if.source                          o_res
);

    hds_pkg::t_result                   r_mem [hds_pkg::FIFO_DEPTH];
    logic [hds_pkg::FIFO_PTR_BITS-1:0]  r_wr_ptr;
    logic [hds_pkg::FIFO_PTR_BITS-1:0]  r_rd_ptr;
    logic [hds_pkg::FIFO_CNT_BITS-1:0]  r_count;
    logic                               w_pop;
    hds_pkg::t_result                   w_head;

    assign w_pop  = o_res.valid && o_res.ready;
    assign w_head = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_count             = r_count;
    assign o_res.valid         = (r_count != '0);
    assign o_res.new_value     = w_head.new_value;
    assign o_res.out_row       = w_head.out_row;
    assign o_res.out_col       = w_head.out_col;
    assign o_res.last_of_frame = w_head.last_of_frame;

    `HDS_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, (r_count < hds_pkg::FIFO_DEPTH) || w_pop, "result queue overflow")
    `HDS_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !w_pop, r_count == $past(r_count) + 1'b1, "queue count did not advance")

endmodule

`default_nettype wire

>>> rtl/heat_diffusion_stencil.sv
// ----------------------------------------------------------------------------
// heat_diffusion_stencil
// one explicit five-point heat-equation step over a streamed padded grid
// ----------------------------------------------------------------------------
//  channel   dir  transfer                        payload
//  i_cell    in   valid & ready                   cell_value
//  o_res     out  valid & ready                   new_value out_row out_col last_of_frame
//  apb       in   psel & penable & pwrite         grid_width grid_height diffusion_gain
//
//  one cell is taken per cycle while i_cell.ready is high; an interior result is offered
//  on o_res once the cell that completes its window has gone through the stages (stage one
//  with line buffer read, window shift and multiply, round and saturate into the queue)
//  i_cell.ready drops once queued results plus cells in flight reach the eight-entry queue
//  reset is synchronous and clears counters, window and queue; line buffers are not cleared
//  writing grid_width or grid_height restarts the frame at row zero, column zero
// ----------------------------------------------------------------------------
`default_nettype none

`include "heat_diffusion_stencil_defines.svh"

module heat_diffusion_stencil (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    hds_in_if.sink                             i_cell,
    hds_out_if.source                          o_res,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [hds_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire  [hds_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [hds_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    // configuration registers
    logic [hds_pkg::WIDTH_REG_BITS-1:0] r_grid_width;
    logic [hds_pkg::ROW_BITS-1:0]       r_grid_height;
    logic [hds_pkg::GAIN_BITS-1:0]      r_gain;

    // raster position
    logic [hds_pkg::COL_BITS-1:0] r_col_cnt;
    logic [hds_pkg::ROW_BITS-1:0] r_row_cnt;
    logic [hds_pkg::COL_BITS-1:0] n_col_cnt;
    logic [hds_pkg::ROW_BITS-1:0] n_row_cnt;

    // stage one
    logic                         r_s1_valid;
    hds_pkg::t_stage              r_s1;
    logic [hds_pkg::COL_BITS-1:0] r_s1_addr;

    logic                               w_cfg_wr;
    logic [hds_pkg::REG_IDX_BITS-1:0]   w_cfg_idx;
    logic                               w_geom_wr;
    logic [hds_pkg::WIDTH_REG_BITS-1:0] w_width_eff;
    logic [hds_pkg::ROW_BITS-1:0]       w_height_eff;
    logic [hds_pkg::COL_BITS-1:0]       w_col_last;
    logic [hds_pkg::ROW_BITS-1:0]       w_row_last;
    logic [hds_pkg::COL_BITS-1:0]       w_col;
    logic [hds_pkg::ROW_BITS-1:0]       w_row;
    hds_pkg::t_meta                     w_meta;
    logic                               w_in_accept;
    logic                               w_frame_start;

    hds_pkg::t_value                    w_rd_above;
    hds_pkg::t_value                    w_rd_two_above;
    hds_pkg::t_pipe_status              w_status;
    hds_pkg::t_result                   w_res;
    logic [hds_pkg::FIFO_CNT_BITS-1:0]  w_fifo_count;
    logic [1:0]                         w_inflight;
    logic [hds_pkg::FIFO_CNT_BITS-1:0]  w_credit;

    // apb decode
    assign w_cfg_idx = paddr[hds_pkg::APB_ADDR_BITS-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_geom_wr = w_cfg_wr
                    && (w_cfg_idx == hds_pkg::REG_GRID_WIDTH
                        || w_cfg_idx == hds_pkg::REG_GRID_HEIGHT);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= hds_pkg::GRID_WIDTH_RST;
            r_grid_height <= hds_pkg::GRID_HEIGHT_RST;
            r_gain        <= hds_pkg::GAIN_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                hds_pkg::REG_GRID_WIDTH: begin
                    r_grid_width <= pwdata[hds_pkg::WIDTH_REG_BITS-1:0];
                end
                hds_pkg::REG_GRID_HEIGHT: begin
                    r_grid_height <= pwdata[hds_pkg::ROW_BITS-1:0];
                end
                hds_pkg::REG_DIFFUSION_GAIN: begin
                    r_gain <= pwdata[hds_pkg::GAIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_cfg_idx)
            hds_pkg::REG_GRID_WIDTH:     prdata = hds_pkg::APB_DATA_BITS'(r_grid_width);
            hds_pkg::REG_GRID_HEIGHT:    prdata = hds_pkg::APB_DATA_BITS'(r_grid_height);
            hds_pkg::REG_DIFFUSION_GAIN: prdata = hds_pkg::APB_DATA_BITS'(r_gain);
            default:                     prdata = '0;
        endcase
    end

    // effective grid size and current position
    always_comb begin
        if (r_grid_width < hds_pkg::WIDTH_REG_BITS'(hds_pkg::MIN_DIM)) begin
            w_width_eff = hds_pkg::WIDTH_REG_BITS'(hds_pkg::MIN_DIM);
        end else if (r_grid_width > hds_pkg::WIDTH_REG_BITS'(hds_pkg::MAX_WIDTH)) begin
            w_width_eff = hds_pkg::WIDTH_REG_BITS'(hds_pkg::MAX_WIDTH);
        end else begin
            w_width_eff = r_grid_width;
        end
        if (r_grid_height < hds_pkg::ROW_BITS'(hds_pkg::MIN_DIM)) begin
            w_height_eff = hds_pkg::ROW_BITS'(hds_pkg::MIN_DIM);
        end else begin
            w_height_eff = r_grid_height;
        end
        w_col_last = hds_pkg::COL_BITS'(w_width_eff - 1'b1);
        w_row_last = w_height_eff - 1'b1;
        w_col = (r_col_cnt > w_col_last) ? w_col_last : r_col_cnt;
        w_row = (r_row_cnt > w_row_last) ? w_row_last : r_row_cnt;

        w_meta.produce = (w_row >= hds_pkg::ROW_BITS'(2)) && (w_col >= hds_pkg::COL_BITS'(2));
        w_meta.row     = w_row - 1'b1;
        w_meta.col     = w_col - 1'b1;
        w_meta.last    = (w_row == w_row_last) && (w_col == w_col_last);

        if (w_col == w_col_last) begin
            n_col_cnt = '0;
            n_row_cnt = (w_row == w_row_last) ? '0 : w_row + 1'b1;
        end else begin
            n_col_cnt = w_col + 1'b1;
            n_row_cnt = w_row;
        end
    end

    // input credit against the result queue
    assign w_inflight = {1'b0, r_s1_valid} + {1'b0, w_status.s2_valid}
                      + {1'b0, w_status.s3_valid};
    assign w_credit   = w_fifo_count + hds_pkg::FIFO_CNT_BITS'(w_inflight);
    assign i_cell.ready = (w_credit < hds_pkg::FIFO_CNT_BITS'(hds_pkg::FIFO_DEPTH));
    assign w_in_accept  = i_cell.valid && i_cell.ready;

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_geom_wr) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_in_accept) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    assign w_frame_start = (r_col_cnt == '0) && (r_row_cnt == '0);

    // stage one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1.x    <= i_cell.cell_value;
            r_s1.meta <= w_meta;
            r_s1_addr <= w_col;
        end
    end

    hds_line_buf u_line_buf (
        .i_clk          (i_clk),
        .i_rd_en        (w_in_accept),
        .i_rd_addr      (w_col),
        .i_wr_en        (r_s1_valid),
        .i_wr_addr      (r_s1_addr),
        .i_wr_x         (r_s1.x),
        .o_rd_above     (w_rd_above),
        .o_rd_two_above (w_rd_two_above)
    );

    hds_update u_update (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s1_valid     (r_s1_valid),
        .i_s1           (r_s1),
        .i_rd_above     (w_rd_above),
        .i_rd_two_above (w_rd_two_above),
        .i_gain         (r_gain),
        .o_status       (w_status),
        .o_res          (w_res)
    );

    hds_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_status.s3_valid),
        .i_data  (w_res),
        .o_count (w_fifo_count),
        .o_res   (o_res)
    );

    `HDS_ASSERT_NEXT(a_accept_s1, i_clk, i_rst_n, w_in_accept, r_s1_valid, "stage one lost a cell")
    `HDS_ASSERT_NEXT(a_geom_restart, i_clk, i_rst_n, w_geom_wr, w_frame_start, "no frame restart")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the five-point heat diffusion stencil: grid cells
// stream in raster order under random source and sink gaps, a scoreboard
// recomputes every interior update and compares each result transfer field
// by field, and geometry and gain are reprogrammed over apb between passes
// ----------------------------------------------------------------------------
module tb_top;
    import hds_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_ITEMS  = 380;
    localparam int unsigned WIDE_ITEMS    = 40;
    localparam longint      ROUND_HALF    = 64'sd32768;
    localparam int          GAIN_SHIFT    = 16;

    // register index that decodes to nothing
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef enum int {PACE_SINK_BOUND, PACE_SOURCE_BOUND, PACE_FULL_RATE} t_pace;

    // 4x4 frame of extremes, every interior cell saturates
    localparam t_value CORNER_GRID [16] = '{
        VAL_MAX, VAL_MIN, VAL_MAX, 16'sd0,
        VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX,
        VAL_MAX, VAL_MIN, 16'sd1,  -16'sd1,
        16'sd0,  VAL_MAX, VAL_MIN, 16'sd256
    };

    // 4x3 frame at gain one half: positive and negative rounding ties, both rounded up
    localparam t_value TIE_GRID [12] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sd0,
        16'sd0, 16'sd0, 16'sd0,  16'sd0,
        16'sd0, 16'sd0, 16'sd0,  16'sd0
    };

    // expected interior updates, recomputed from the accepted cell stream
    class diffusion_scoreboard;
        logic [WIDTH_REG_BITS-1:0] width_reg;
        logic [ROW_BITS-1:0]       height_reg;
        logic [GAIN_BITS-1:0]      gain_reg;
        t_value                    above_row [MAX_WIDTH];
        t_value                    two_above_row [MAX_WIDTH];
        t_value                    win [3][3];
        int unsigned               col;
        int unsigned               row;
        t_result                   queued_updates [$];
        int unsigned               errors;

        function new();
            width_reg  = GRID_WIDTH_RST;
            height_reg = GRID_HEIGHT_RST;
            gain_reg   = GAIN_RST;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                above_row[i]     = '0;
                two_above_row[i] = '0;
            end
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    win[k][j] = '0;
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        function int unsigned frame_width();
            if (width_reg < MIN_DIM) return MIN_DIM;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned frame_height();
            return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        endfunction

        function int unsigned pending_count();
            return queued_updates.size();
        endfunction

        // geometry writes restart the frame
        function void apply_register(logic [REG_IDX_BITS-1:0] idx,
                                     logic [APB_DATA_BITS-1:0] data);
            case (idx)
                REG_GRID_WIDTH: begin
                    width_reg = data[WIDTH_REG_BITS-1:0];
                    col = 0;
                    row = 0;
                end
                REG_GRID_HEIGHT: begin
                    height_reg = data[ROW_BITS-1:0];
                    col = 0;
                    row = 0;
                end
                REG_DIFFUSION_GAIN: gain_reg = data[GAIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void accept_cell(t_value x);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            longint      u;
            longint      lap;
            longint      prod;
            longint      sum;
            t_result     upd;
            w = frame_width();
            h = frame_height();
            c = (col >= w) ? w - 1 : col;
            r = (row >= h) ? h - 1 : row;

            // slide the window and rotate the line buffers
            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = two_above_row[c];
            win[1][2] = above_row[c];
            win[2][2] = x;
            two_above_row[c] = above_row[c];
            above_row[c]     = x;

            // interior cell centered in the window
            if (r >= 2 && c >= 2) begin
                u    = longint'(win[1][1]);
                lap  = longint'(win[0][1]) + longint'(win[2][1]) + longint'(win[1][0])
                     + longint'(win[1][2]) - 4 * u;
                prod = longint'(gain_reg) * lap;
                sum  = u + ((prod + ROUND_HALF) >>> GAIN_SHIFT);
                if (sum > longint'(VAL_MAX)) sum = longint'(VAL_MAX);
                if (sum < longint'(VAL_MIN)) sum = longint'(VAL_MIN);
                upd.new_value     = t_value'(sum);
                upd.out_row       = ROW_BITS'(r - 1);
                upd.out_col       = COL_BITS'(c - 1);
                upd.last_of_frame = (r == h - 1) && (c == w - 1);
                queued_updates.push_back(upd);
            end

            // raster counters
            if (c + 1 >= w) begin
                col = 0;
                row = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col = c + 1;
                row = r;
            end
        endfunction

        function void check_update(t_result got);
            t_result want;
            if (queued_updates.size() == 0) begin
                $error("unexpected update: row %0d col %0d value %0d",
                       got.out_row, got.out_col, got.new_value);
                errors++;
                return;
            end
            want = queued_updates.pop_front();
            if (got.new_value !== want.new_value) begin
                $error("new_value: expected %0d, actual %0d", want.new_value, got.new_value);
                errors++;
            end
            if (got.out_row !== want.out_row) begin
                $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
                errors++;
            end
            if (got.out_col !== want.out_col) begin
                $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $error("last_of_frame: expected %0b, actual %0b",
                       want.last_of_frame, got.last_of_frame);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    hds_in_if  cell_if ();
    hds_out_if res_if ();

    diffusion_scoreboard sb;
    t_pace               pace_mode    = PACE_SINK_BOUND;
    int unsigned         hold_trigger = 0;
    int unsigned         random_items = 0;
    int unsigned         cycle_count  = 0;

    heat_diffusion_stencil u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned source_idle_pct();
        case (pace_mode)
            PACE_SINK_BOUND:   return 24;
            PACE_SOURCE_BOUND: return 75;
            default:           return 0;
        endcase
    endfunction

    function automatic int unsigned sink_idle_pct();
        case (pace_mode)
            PACE_SINK_BOUND:   return 75;
            PACE_SOURCE_BOUND: return 24;
            default:           return 0;
        endcase
    endfunction

    // cell transfer into the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && cell_if.valid && cell_if.ready)
            sb.accept_cell(cell_if.cell_value);
    end

    // result transfer against the oldest expected update
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.new_value     = res_if.new_value;
            got.out_row       = res_if.out_row;
            got.out_col       = res_if.out_col;
            got.last_of_frame = res_if.last_of_frame;
            sb.check_update(got);
        end
    end

    // result sink: random stalls plus long hold-offs on request
    initial begin : result_sink
        int unsigned held;
        int unsigned seen;
        res_if.ready = 1'b0;
        held = 0;
        seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_trigger != seen) begin
                seen = hold_trigger;
                held = HOLD_CYCLES;
            end
            if (held != 0) begin
                held--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= sink_idle_pct());
            end
        end
    end

    // apb write: setup then access phase
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.apply_register(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_geometry(input int unsigned width, input int unsigned height,
                                  input int unsigned gain);
        write_reg(REG_GRID_WIDTH, width);
        write_reg(REG_DIFFUSION_GAIN, gain);
        write_reg(REG_GRID_HEIGHT, height);
    endtask

    // one cell transfer, called and returning at a falling edge
    task automatic send_cell(input t_value v);
        while ($urandom_range(99) < source_idle_pct()) begin
            cell_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.cell_value <= v;
        do @(posedge i_clk); while (!cell_if.ready);
        @(negedge i_clk);
    endtask

    // stop the source and wait for every expected update plus pipeline slack
    task automatic settle();
        cell_if.valid <= 1'b0;
        while (sb.pending_count() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_value random_cell();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) return $urandom_range(1) ? VAL_MAX : VAL_MIN;
        if (pick < 40) return t_value'(int'($urandom_range(1023)) - 512);
        return t_value'($urandom_range(65535));
    endfunction

    function automatic int unsigned random_gain();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) return 0;
        if (pick < 16) return 65535;
        if (pick < 24) return GAIN_RST;
        return $urandom_range(65535);
    endfunction

    task automatic stream_cells(input int unsigned count);
        repeat (count) send_cell(random_cell());
    endtask

    // one pass: new gain mid-frame, or new geometry and whole or broken frames
    task automatic run_random_phase();
        int unsigned width;
        int unsigned height;
        int unsigned pick;
        int unsigned count;
        settle();
        pick = $urandom_range(99);
        if (pick < 25) begin
            write_reg(REG_DIFFUSION_GAIN, random_gain());
            count = $urandom_range(60, 5);
        end else begin
            pick   = $urandom_range(99);
            width  = (pick < 10) ? $urandom_range(2, 0) : $urandom_range(12, 3);
            pick   = $urandom_range(99);
            if (pick < 8)
                height = $urandom_range(2, 0);
            else if (pick < 16)
                height = $urandom_range(1) ? 65535 : $urandom_range(65535, 9);
            else
                height = $urandom_range(8, 3);
            write_geometry(width, height, random_gain());
            if ($urandom_range(9) == 0)
                write_reg(REG_UNUSED, $urandom());
            if (sb.frame_height() > 8)
                count = sb.frame_width() * $urandom_range(6, 3);
            else
                count = sb.frame_width() * sb.frame_height() * $urandom_range(3, 1);
            if ($urandom_range(4) == 0)
                count = $urandom_range(count, 1);
        end
        stream_cells(count);
        random_items += count;
    endtask

    initial begin
        sb = new();
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cell_if.valid      = 1'b0;
        cell_if.cell_value = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: saturation both ways at near-unity gain
        write_geometry(4, 4, 65535);
        foreach (CORNER_GRID[i]) send_cell(CORNER_GRID[i]);
        settle();

        // directed: rounding ties at gain one half, short height clamped up
        write_geometry(4, 2, 32768);
        foreach (TIE_GRID[i]) send_cell(TIE_GRID[i]);

        // random passes under the three pacing schemes
        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3)
                pace_mode = PACE_SINK_BOUND;
            else if (random_items < 2 * RANDOM_ITEMS / 3)
                pace_mode = PACE_SOURCE_BOUND;
            else
                pace_mode = PACE_FULL_RATE;
            run_random_phase();
        end

        // sink holds off while cells keep coming, input must back up
        settle();
        pace_mode = PACE_FULL_RATE;
        write_geometry(6, 30, random_gain());
        hold_trigger++;
        stream_cells(180);

        // widest grid, width register above the line buffer size, partial first row
        settle();
        write_geometry(2047, 3, random_gain());
        stream_cells(WIDE_ITEMS);

        settle();
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
